@@ design/lfpw_pkg.sv @@
package lfpw_pkg;

  localparam int WIDTH_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int BITPOS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 2'd2;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 8'd13;
  localparam logic [WIDTH_W-1:0] MID_WIDTH_RESET = 8'd23;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 8'd40;

  // Operation codes of an input transaction.
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [BYTE_W-1:0]   BIT_MASK_MSB = 8'h80;
  localparam logic [BITPOS_W-1:0] BITPOS_LAST  = 3'd7;

  typedef struct packed {
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] mid_width;
    logic [WIDTH_W-1:0] max_width;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] code_byte;
  } result_t;

endpackage

@@ design/lfpw_if.sv @@
interface lfpw_in_if import lfpw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [WIDTH_W-1:0] interval;

  modport source (output valid, output operation, output interval, input ready);
  modport sink   (input valid, input operation, input interval, output ready);
endinterface

interface lfpw_out_if import lfpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface lfpw_cfg_if import lfpw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/lfpw_cfg_regs.sv @@
module lfpw_cfg_regs import lfpw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  lfpw_cfg_if.sink cfg,
  output cfg_t     regs
);

  assign cfg.ready = 1'b1;

  // Writes to an index beyond the three registers are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_width <= MIN_WIDTH_RESET;
      regs.mid_width <= MID_WIDTH_RESET;
      regs.max_width <= MAX_WIDTH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MIN_WIDTH: regs.min_width <= cfg.data;
        CFG_MID_WIDTH: regs.mid_width <= cfg.data;
        CFG_MAX_WIDTH: regs.max_width <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/lfpw_decode_core.sv @@
module lfpw_decode_core import lfpw_pkg::*; #(
  parameter int FRAME_COPIES = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               operation,
  input  logic [WIDTH_W-1:0] interval,
  input  cfg_t               regs,
  output result_t            result
);

  localparam int CIDX_W = $clog2(FRAME_COPIES);
  localparam logic [CIDX_W-1:0] CIDX_LAST = CIDX_W'(FRAME_COPIES - 1);

  typedef enum logic [1:0] {
    PHASE_IDLE      = 2'b01,
    PHASE_RECEIVING = 2'b10
  } phase_t;

  phase_t              phase, phase_next;
  logic [BITPOS_W-1:0] bit_position, bit_position_next;
  logic [CIDX_W-1:0]   copy_index, copy_index_next;
  logic [BYTE_W-1:0]   copy_bytes [FRAME_COPIES];
  logic [BYTE_W-1:0]   copy_bytes_next [FRAME_COPIES];
  logic [BYTE_W-1:0]   last_reported, last_reported_next;

  always_comb begin
    logic [BYTE_W-1:0] mask;
    logic [CIDX_W-1:0] cur;
    logic              agree;
    phase_next         = phase;
    bit_position_next  = bit_position;
    copy_index_next    = copy_index;
    copy_bytes_next    = copy_bytes;
    last_reported_next = last_reported;
    result             = '0;
    mask               = BIT_MASK_MSB >> bit_position;
    cur                = (int'(copy_index) >= FRAME_COPIES) ? '0 : copy_index;
    agree              = 1'b0;
    if (accept) begin
      if (operation == OP_TIMEOUT) begin
        phase_next = PHASE_IDLE;
      end else if (phase != PHASE_RECEIVING) begin
        // The arming edge starts a fresh frame; its interval means nothing.
        for (int k = 0; k < FRAME_COPIES; k++) begin
          copy_bytes_next[k] = '0;
        end
        bit_position_next = '0;
        copy_index_next   = '0;
        phase_next        = PHASE_RECEIVING;
      end else if (interval < regs.min_width || interval > regs.max_width) begin
        phase_next = PHASE_IDLE;
      end else begin
        if (interval > regs.mid_width) begin
          copy_bytes_next[cur] = copy_bytes[cur] | mask;
        end else begin
          copy_bytes_next[cur] = copy_bytes[cur] & ~mask;
        end
        copy_index_next = cur;
        if (bit_position != BITPOS_LAST) begin
          bit_position_next = bit_position + 1'b1;
        end else begin
          bit_position_next = '0;
          if (cur != CIDX_LAST) begin
            copy_index_next = cur + 1'b1;
          end else begin
            // Last bit of the last copy: vote over all copies.
            phase_next      = PHASE_IDLE;
            copy_index_next = '0;
            agree           = (copy_bytes_next[0] != '0);
            for (int k = 1; k < FRAME_COPIES; k++) begin
              if (copy_bytes_next[k] != copy_bytes_next[0]) begin
                agree = 1'b0;
              end
            end
            if (!agree) begin
              for (int k = 0; k < FRAME_COPIES; k++) begin
                copy_bytes_next[k] = '0;
              end
            end else if (copy_bytes_next[0] != last_reported) begin
              last_reported_next = copy_bytes_next[0];
              result.valid       = 1'b1;
              result.code_byte   = copy_bytes_next[0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_IDLE;
      bit_position  <= '0;
      copy_index    <= '0;
      last_reported <= '0;
      for (int k = 0; k < FRAME_COPIES; k++) begin
        copy_bytes[k] <= '0;
      end
    end else begin
      phase         <= phase_next;
      bit_position  <= bit_position_next;
      copy_index    <= copy_index_next;
      last_reported <= last_reported_next;
      copy_bytes    <= copy_bytes_next;
    end
  end

endmodule

@@ design/lfpw_out_buffer.sv @@
module lfpw_out_buffer import lfpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  result_t     result,
  output logic        space,
  lfpw_out_if.source  codes
);

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              skid_valid;
  logic [BYTE_W-1:0] skid_byte;

  // A new result can always be held while the skid stage is empty.
  assign space           = !skid_valid;
  assign codes.valid     = out_valid;
  assign codes.code_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !codes.ready) begin
      if (result.valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !codes.ready) begin
      if (result.valid) begin
        skid_byte <= result.code_byte;
      end
    end else if (skid_valid) begin
      out_byte <= skid_byte;
    end else if (result.valid) begin
      out_byte <= result.code_byte;
    end
  end

endmodule

@@ design/lf_pulse_width_triple_vote_decoder.sv @@
// Pulse-width bit decoder with repeated-copy voting. Each transaction on
// events is a rising edge (operation 0, interval = timer ticks since the
// previous edge) or a timer-overflow timeout (operation 1). The first edge
// after idle arms the decoder; each later edge gives one bit, MSB first, set
// when the interval is above mid_width. An interval below min_width or above
// max_width aborts the frame, and a timeout returns the decoder to idle.
// After FRAME_COPIES bytes, the byte is sent on codes if all copies agree,
// are nonzero and differ from the last byte sent. The block takes one event
// transaction every cycle while the skid register is empty. A result is
// held in a two-entry output stage (output register plus skid register),
// which lets events keep flowing while codes is stalled until the skid
// register is full. Configuration writes on cfg take effect in the cycle
// after the transaction and are always accepted.
module lf_pulse_width_triple_vote_decoder import lfpw_pkg::*; #(
  parameter int FRAME_COPIES = 3
) (
  input  logic       clk,
  input  logic       rst,
  lfpw_in_if.sink    events,
  lfpw_out_if.source codes,
  lfpw_cfg_if.sink   cfg
);

  cfg_t    regs;
  result_t result;
  logic    space;
  logic    accept;

  // Events are taken whenever the output stage can hold one more result.
  assign events.ready = space;
  assign accept       = events.valid && space;

  lfpw_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Frame state and the per-edge decode, compare and vote logic.
  lfpw_decode_core #(
    .FRAME_COPIES (FRAME_COPIES)
  ) u_decode_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (events.operation),
    .interval  (events.interval),
    .regs      (regs),
    .result    (result)
  );

  // Result register and skid stage in front of the codes channel.
  lfpw_out_buffer u_out_buffer (
    .clk    (clk),
    .rst    (rst),
    .result (result),
    .space  (space),
    .codes  (codes)
  );

endmodule

@@ design/lfpw_checker.sv @@
module lfpw_checker import lfpw_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              ev_valid,
  input logic              ev_ready,
  input logic              ev_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte
);

  logic [BYTE_W-1:0] last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte <= '0;
    end else if (out_valid && out_ready) begin
      last_byte <= out_byte;
    end
  end

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("codes payload changed while stalled");

  // Reported bytes are nonzero and never repeat the previous report.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_byte != '0 && out_byte != last_byte)
    else $error("code byte zero or equal to the last reported byte");

  // A new result only follows an accepted edge event.
  a_from_edge: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ev_valid && ev_ready && ev_operation == OP_EDGE))
    else $error("result without a preceding edge event");

  // While the output register is empty, events are always taken.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ev_ready)
    else $error("events stalled with an empty output");

endmodule

bind lf_pulse_width_triple_vote_decoder lfpw_checker u_lfpw_checker (
  .clk          (clk),
  .rst          (rst),
  .ev_valid     (events.valid),
  .ev_ready     (events.ready),
  .ev_operation (events.operation),
  .out_valid    (codes.valid),
  .out_ready    (codes.ready),
  .out_byte     (codes.code_byte)
);

@@ sim/tb.sv @@
module tb import lfpw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration and the pacing knobs of the bench.
  localparam int FRAME_COPIES     = 3;
  localparam int MAX_IDLE         = 17;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RANDOM_ITEMS     = 800;
  localparam int CFG_PERIOD       = 150;
  localparam int BREAK_PERMILLE   = 8;

  // Index 3 addresses no register; writes to it must leave the widths alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {RX_IDLE, RX_RECEIVING} rx_phase_t;
  typedef logic [FRAME_COPIES-1:0][BYTE_W-1:0] frame_t;

  logic clk = 1'b0;
  logic rst;

  lfpw_in_if  events_if ();
  lfpw_out_if codes_if ();
  lfpw_cfg_if cfg_if ();

  lf_pulse_width_triple_vote_decoder #(.FRAME_COPIES(FRAME_COPIES)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .events (events_if),
    .codes  (codes_if),
    .cfg    (cfg_if)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow state. It is updated in the same time step as each accepted
  // transaction, so the expected code is queued before the block can answer.
  // ---------------------------------------------------------------------------
  cfg_t                  width_cfg;
  rx_phase_t             rx_phase;
  logic [BITPOS_W-1:0]   rx_bit;
  int                    rx_copy;
  logic [BYTE_W-1:0]     rx_copies [FRAME_COPIES];
  logic [BYTE_W-1:0]     last_code;
  logic [BYTE_W-1:0]     expected_codes [$];

  // Run statistics and the error tally.
  int events_accepted = 0;
  int codes_predicted = 0;
  int codes_checked   = 0;
  int reg_writes      = 0;
  int frames_sent     = 0;
  int error_count     = 0;
  int idle_cycles     = 0;

  // Pacing controls shared by the stimulus tasks and the code receiver.
  bit send_gapless = 1'b0;
  bit recv_gapless = 1'b0;
  bit hold_req     = 1'b0;

  function automatic void clear_copies();
    int k;
    for (k = 0; k < FRAME_COPIES; k++) rx_copies[k] = '0;
  endfunction

  function automatic void decoder_reset();
    width_cfg.min_width = MIN_WIDTH_RESET;
    width_cfg.mid_width = MID_WIDTH_RESET;
    width_cfg.max_width = MAX_WIDTH_RESET;
    rx_phase  = RX_IDLE;
    rx_bit    = '0;
    rx_copy   = 0;
    last_code = '0;
    clear_copies();
  endfunction

  // Advances the shadow decoder by one event and queues the code it yields.
  function automatic void decode_event(input logic op, input logic [WIDTH_W-1:0] ticks);
    logic [BYTE_W-1:0] mask;
    logic              agree;
    int                k;
    // A timeout only drops back to idle; the copies and the last code stay.
    if (op == OP_TIMEOUT) begin
      rx_phase = RX_IDLE;
      return;
    end
    // The arming edge starts a fresh frame and its interval means nothing.
    if (rx_phase != RX_RECEIVING) begin
      clear_copies();
      rx_bit   = '0;
      rx_copy  = 0;
      rx_phase = RX_RECEIVING;
      return;
    end
    // An interval outside the window aborts the frame. With min above max
    // this is every edge after the arming one.
    if (ticks < width_cfg.min_width || ticks > width_cfg.max_width) begin
      rx_phase = RX_IDLE;
      return;
    end
    mask = BIT_MASK_MSB >> rx_bit;
    if (ticks > width_cfg.mid_width) begin
      rx_copies[rx_copy] = rx_copies[rx_copy] | mask;
    end else begin
      rx_copies[rx_copy] = rx_copies[rx_copy] & ~mask;
    end
    if (rx_bit != BITPOS_LAST) begin
      rx_bit = rx_bit + 1'b1;
      return;
    end
    rx_bit = '0;
    if (rx_copy + 1 < FRAME_COPIES) begin
      rx_copy++;
      return;
    end
    // Every copy is in: vote. Disagreeing or all-zero copies are discarded,
    // and a byte equal to the last code is swallowed silently.
    rx_phase = RX_IDLE;
    rx_copy  = 0;
    agree    = (rx_copies[0] != '0);
    for (k = 1; k < FRAME_COPIES; k++) begin
      if (rx_copies[k] != rx_copies[0]) agree = 1'b0;
    end
    if (!agree) begin
      clear_copies();
      return;
    end
    if (rx_copies[0] == last_code) return;
    last_code = rx_copies[0];
    expected_codes.push_back(last_code);
    codes_predicted++;
  endfunction

  // ---------------------------------------------------------------------------
  // Event sender. Valid is left high after a transaction so that a zero gap
  // keeps it high for the next one; a nonzero gap lowers it first. Either way
  // valid gets a single nonblocking assignment per time step.
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic op, input logic [WIDTH_W-1:0] ticks);
    int gap;
    gap = send_gapless ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      events_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    events_if.valid     <= 1'b1;
    events_if.operation <= op;
    events_if.interval  <= ticks;
    do @(posedge clk); while (!(events_if.valid && events_if.ready));
    decode_event(op, ticks);
    events_accepted++;
  endtask

  // Lowers valid and waits until every expected code has come out, then waits
  // out the drain period so that a frame that yields nothing has also settled.
  task automatic wait_idle();
    events_if.valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One configuration transaction; the trailing idle wait keeps the lowering of
  // valid apart from the raising of the next write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      CFG_MIN_WIDTH: width_cfg.min_width = value;
      CFG_MID_WIDTH: width_cfg.mid_width = value;
      CFG_MAX_WIDTH: width_cfg.max_width = value;
      default: ;
    endcase
    reg_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_widths(input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] mid,
                            input logic [WIDTH_W-1:0] hi);
    wait_idle();
    write_reg(CFG_MIN_WIDTH, lo);
    write_reg(CFG_MID_WIDTH, mid);
    write_reg(CFG_MAX_WIDTH, hi);
  endtask

  // Picks an interval that decodes as the wanted bit under the current widths,
  // often right on a boundary. When that bit cannot be encoded it falls back
  // to the other bit, and when neither can it returns any interval at all.
  function automatic logic [WIDTH_W-1:0] pick_interval(input logic one);
    int lo1, hi1, lo0, hi0, lo, hi;
    lo1 = int'(width_cfg.mid_width) + 1;
    if (lo1 < int'(width_cfg.min_width)) lo1 = int'(width_cfg.min_width);
    hi1 = int'(width_cfg.max_width);
    lo0 = int'(width_cfg.min_width);
    hi0 = (width_cfg.mid_width < width_cfg.max_width) ? int'(width_cfg.mid_width)
                                                       : int'(width_cfg.max_width);
    if (one && lo1 <= hi1) begin
      lo = lo1;
      hi = hi1;
    end else if (lo0 <= hi0) begin
      lo = lo0;
      hi = hi0;
    end else if (lo1 <= hi1) begin
      lo = lo1;
      hi = hi1;
    end else begin
      return WIDTH_W'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 3))
      0:       return WIDTH_W'(lo);
      1:       return WIDTH_W'(hi);
      default: return WIDTH_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Breaks a frame with a timeout or, where the window allows one, an
  // interval outside it.
  task automatic send_break();
    if ($urandom_range(0, 1) == 0) begin
      send_event(OP_TIMEOUT, WIDTH_W'($urandom_range(0, 255)));
    end else if (width_cfg.min_width > 0) begin
      send_event(OP_EDGE, WIDTH_W'($urandom_range(0, int'(width_cfg.min_width) - 1)));
    end else if (width_cfg.max_width < 8'hFF) begin
      send_event(OP_EDGE, WIDTH_W'($urandom_range(int'(width_cfg.max_width) + 1, 255)));
    end else begin
      send_event(OP_TIMEOUT, WIDTH_W'($urandom_range(0, 255)));
    end
  endtask

  // An arming edge followed by every copy, MSB first. A frame may be cut
  // short at random by a break.
  task automatic send_frame(input frame_t frame, input int break_permille);
    int c, b;
    send_event(OP_EDGE, WIDTH_W'($urandom_range(0, 255)));
    for (c = 0; c < FRAME_COPIES; c++) begin
      for (b = BYTE_W - 1; b >= 0; b--) begin
        if (break_permille > 0 && $urandom_range(1, 1000) <= break_permille) begin
          send_break();
          return;
        end
        send_event(OP_EDGE, pick_interval(frame[c][b]));
      end
    end
    frames_sent++;
  endtask

  // Random frame content: mostly fresh bytes, with some zero bytes, repeats
  // of the last code and frames where one copy disagrees.
  task automatic send_random_frame();
    frame_t            frame;
    logic [BYTE_W-1:0] value;
    int                r, k;
    r     = $urandom_range(0, 99);
    value = BYTE_W'($urandom_range(1, 255));
    if (r < 8) value = '0;
    else if (r < 20) value = last_code;
    for (k = 0; k < FRAME_COPIES; k++) frame[k] = value;
    if (r >= 20 && r < 35) begin
      k = $urandom_range(0, FRAME_COPIES - 1);
      frame[k] = frame[k] ^ BYTE_W'($urandom_range(1, 255));
    end
    send_frame(frame, BREAK_PERMILLE);
  endtask

  // Unstructured traffic: any operation with any interval.
  task automatic send_noise(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_event(($urandom_range(0, 3) == 0) ? OP_TIMEOUT : OP_EDGE,
                 WIDTH_W'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset widths: the arming edge, both kinds of out-of-window abort, a
  // timeout mid-frame, then one clean frame that must yield its byte.
  task automatic test_directed_cases();
    frame_t frame;
    send_event(OP_TIMEOUT, 8'hFF);
    send_event(OP_EDGE, 8'hFF);
    send_event(OP_EDGE, MIN_WIDTH_RESET - 1'b1);
    send_event(OP_EDGE, 8'h00);
    send_event(OP_EDGE, MAX_WIDTH_RESET + 1'b1);
    send_event(OP_EDGE, 8'h00);
    send_event(OP_TIMEOUT, 8'h00);
    frame = {FRAME_COPIES{8'hA5}};
    send_frame(frame, 0);
  endtask

  // Each register at its extremes, a write to the unused index, and a window
  // with min above max where every data edge aborts.
  task automatic test_register_extremes();
    int n;
    set_widths(8'd0, 8'd0, 8'd255);
    for (n = 0; n < 3; n++) send_random_frame();
    wait_idle();
    write_reg(CFG_SPARE, 8'hFF);
    for (n = 0; n < 2; n++) send_random_frame();
    set_widths(8'd0, 8'd254, 8'd255);
    for (n = 0; n < 3; n++) send_random_frame();
    // Only 255 fits and it always decodes as zero, so nothing comes out.
    set_widths(8'd255, 8'd255, 8'd255);
    for (n = 0; n < 2; n++) send_random_frame();
    send_noise(6);
    set_widths(8'd200, 8'd150, 8'd100);
    send_random_frame();
    send_noise(10);
    wait_idle();
    write_reg(CFG_SPARE, 8'h00);
    set_widths(MIN_WIDTH_RESET, MID_WIDTH_RESET, MAX_WIDTH_RESET);
    send_random_frame();
  endtask

  // The bulk of the run: random well-formed windows, mostly complete frames
  // with random content, the rest noise.
  task automatic test_random_traffic();
    int start_items, last_cfg;
    int lo, mid, hi;
    start_items = events_accepted;
    last_cfg    = events_accepted;
    while (events_accepted - start_items < RANDOM_ITEMS) begin
      if (events_accepted - last_cfg >= CFG_PERIOD) begin
        lo  = $urandom_range(0, 200);
        mid = $urandom_range(lo, 254);
        hi  = $urandom_range(mid + 1, 255);
        set_widths(WIDTH_W'(lo), WIDTH_W'(mid), WIDTH_W'(hi));
        last_cfg = events_accepted;
      end
      if ($urandom_range(0, 99) < 80) send_random_frame();
      else send_noise($urandom_range(1, 3));
    end
  endtask

  // Back-to-back transactions on both sides with no idling at all.
  task automatic test_gapless_flow();
    int n;
    wait_idle();
    send_gapless = 1'b1;
    recv_gapless = 1'b1;
    for (n = 0; n < 4; n++) send_random_frame();
    wait_idle();
    send_gapless = 1'b0;
    recv_gapless = 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender streams frames
  // that each yield a new code, so the output stage fills and events stall.
  task automatic test_output_backpressure();
    frame_t            frame;
    logic [BYTE_W-1:0] value;
    int                n, k;
    wait_idle();
    send_gapless = 1'b1;
    hold_req     = 1'b1;
    for (n = 0; n < 8; n++) begin
      do value = BYTE_W'($urandom_range(1, 255)); while (value == last_code);
      for (k = 0; k < FRAME_COPIES; k++) frame[k] = value;
      send_frame(frame, 0);
    end
    send_gapless = 1'b0;
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Code receiver. Before each transaction it stalls for a random number of
  // cycles, or for the long hold when one is requested; ready is only ever
  // assigned once per time step.
  // ---------------------------------------------------------------------------
  initial begin : code_receiver
    int stall;
    codes_if.ready = 1'b0;
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = recv_gapless ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        codes_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      codes_if.ready <= 1'b1;
      do @(posedge clk); while (!(codes_if.valid && codes_if.ready));
    end
  end

  // Every code transaction is checked against the oldest expected code.
  always @(posedge clk) begin
    if (!rst && codes_if.valid && codes_if.ready) begin
      if (expected_codes.size() == 0) begin
        $error("code_byte with no expected result: expected none, actual 0x%02h",
               codes_if.code_byte);
        error_count++;
      end else begin
        if (codes_if.code_byte !== expected_codes[0]) begin
          $error("code_byte mismatch: expected 0x%02h, actual 0x%02h",
                 expected_codes[0], codes_if.code_byte);
          error_count++;
        end
        void'(expected_codes.pop_front());
      end
      codes_checked++;
    end
  end

  // Watchdog: a long run of cycles without any transaction means the block
  // has hung or lost a code.
  always @(posedge clk) begin
    if ((events_if.valid && events_if.ready) || (codes_if.valid && codes_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("lf_pulse_width_triple_vote_decoder verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset once, run the tests in turn, drain and report.
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst                 = 1'b1;
    events_if.valid     = 1'b0;
    events_if.operation = OP_EDGE;
    events_if.interval  = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_MIN_WIDTH;
    cfg_if.data         = '0;
    decoder_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    test_gapless_flow();
    test_output_backpressure();
    wait_idle();

    $display("Run covered %0d event transactions in %0d complete frames, %0d of %0d codes checked,",
             events_accepted, frames_sent, codes_checked, codes_predicted);
    $display("with %0d register writes across reset, extreme and random width settings.",
             reg_writes);
    if (error_count == 0) begin
      $display("lf_pulse_width_triple_vote_decoder verification clean");
    end else begin
      $display("lf_pulse_width_triple_vote_decoder verification failed");
    end
    $finish;
  end

endmodule

@@ lf_pulse_width_triple_vote_decoder.f @@
design/lfpw_pkg.sv
design/lfpw_if.sv
design/lfpw_cfg_regs.sv
design/lfpw_decode_core.sv
design/lfpw_out_buffer.sv
design/lf_pulse_width_triple_vote_decoder.sv
design/lfpw_checker.sv
sim/tb.sv
